>>> rtl/core/bmhpq_pkg.sv
// Package for the binary min-heap priority queue: field widths, the heap
// entry type and the result status codes. No dependencies.
`timescale 1ns / 1ps

package bmhpq_pkg;

  // Default number of heap slots in the entry memory.
  localparam int unsigned HeapDepthDefault = 1024;

  localparam int unsigned PrioW  = 31;
  localparam int unsigned ValW   = 32;
  localparam int unsigned CountW = 11;

  // Reset value of the capacity limit register.
  localparam logic [CountW-1:0] LimitReset = 11'd1024;

  typedef struct packed {
    logic signed [ValW-1:0] val;
    logic [PrioW-1:0]       prio;
  } entry_t;

  typedef enum logic [1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_e;

endpackage

>>> rtl/core/bmhpq_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module bmhpq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/binary_min_heap_priority_queue.sv
// Binary min-heap priority queue of (priority, value) pairs.
// Depends on bmhpq_pkg and on the entry memory bmhpq_ram.
`timescale 1ns / 1ps

// The queue holds up to min(capacity limit, HEAP_DEPTH) entries in a single
// synchronous RAM with one write port and one read port, root at address 0.
// Each input item is either an insert (tuser 0) or a removal of the entry
// with the smallest priority (tuser 1), and each produces exactly one result
// item carrying a status, the removed pair (zero unless a removal succeeded)
// and the entry count after the operation. Items are handled one at a time.
// An insert percolates up one level at a time (read the parent, then
// compare and write back). A removal reads the root and the last entry,
// then sifts down level by level (read left child, read right child, pick
// the smaller, compare and write). Refused inserts and removals from an
// empty heap go straight to the result. These steps follow from the single
// read port of the entry memory. Priority ties are resolved in favor of
// the entry already in place when moving up and in favor of the left child
// when moving down. A finished result sits in an output register, so the
// block goes back to accepting items while that result waits. The capacity
// limit is to be written through cfg_we_i and cfg_wdata_i only while the
// queue is idle; the block itself does not enforce this. Lowering it below
// the current count keeps the entries already held.
module binary_min_heap_priority_queue #(
  parameter int unsigned HEAP_DEPTH = bmhpq_pkg::HeapDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration: capacity limit.
  input  logic        cfg_we_i,
  input  logic [10:0] cfg_wdata_i,
  // Input items.
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [30:0] priority_req, [62:31] value, [63] zero fill
  input  logic [63:0] s_axis_tdata_i,
  // [0] action: 0 insert, 1 remove minimum
  input  logic        s_axis_tuser_i,
  // Result items.
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [30:0] out_priority, [62:31] out_value, [73:63] entry_count, [79:74] zero
  output logic [79:0] m_axis_tdata_o,
  // [1:0] status
  output logic [1:0]  m_axis_tuser_o
);

  localparam int unsigned AddrW = $clog2(HEAP_DEPTH);
  localparam int unsigned CntW  = $clog2(HEAP_DEPTH + 1);
  localparam int unsigned CmpW  = (CntW > bmhpq_pkg::CountW) ? CntW : bmhpq_pkg::CountW;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INS_RD,
    ST_INS_CMP,
    ST_RM_ROOT,
    ST_RM_LAST,
    ST_RM_CAP,
    ST_SD_CHK,
    ST_SD_LEFT,
    ST_SD_RIGHT,
    ST_SD_DEC,
    ST_FIN
  } state_e;

  state_e                          state_q;
  logic [bmhpq_pkg::CountW-1:0]    limit_q;
  logic [CntW-1:0]                 occ_q;
  logic [AddrW-1:0]                pos_q;
  logic [AddrW-1:0]                last_idx_q;
  logic [AddrW-1:0]                child_idx_q;
  bmhpq_pkg::entry_t               new_q;
  bmhpq_pkg::entry_t               child_q;

  // Result under construction, and the output register.
  bmhpq_pkg::status_e              res_status_q;
  bmhpq_pkg::entry_t               res_entry_q;
  logic [bmhpq_pkg::CountW-1:0]    res_cnt_q;
  logic                            m_valid_q;
  bmhpq_pkg::status_e              out_status_q;
  bmhpq_pkg::entry_t               out_entry_q;
  logic [bmhpq_pkg::CountW-1:0]    out_cnt_q;

  // Entry memory ports.
  logic                            ram_we;
  logic [AddrW-1:0]                ram_waddr;
  bmhpq_pkg::entry_t               ram_wdata;
  logic                            ram_re;
  logic [AddrW-1:0]                ram_raddr;
  bmhpq_pkg::entry_t               ram_rdata;

  logic                            in_accept;
  logic                            out_load;
  logic                            heap_full;
  logic [AddrW-1:0]                parent_idx;
  logic [AddrW:0]                  left_idx;
  logic [AddrW:0]                  right_idx;
  logic                            left_ok;
  logic                            right_ok;
  bmhpq_pkg::entry_t               in_entry;
  logic [CntW-1:0]                 occ_inc;
  logic [CntW-1:0]                 occ_dec;
  // Counts brought to a common width before they are reported.
  logic [CmpW-1:0]                 occ_wide;
  logic [CmpW-1:0]                 inc_wide;
  logic [CmpW-1:0]                 dec_wide;

  bmhpq_ram #(
    .Width ($bits(bmhpq_pkg::entry_t)),
    .Depth (HEAP_DEPTH)
  ) u_heap_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;

  // The entry layout matches tdata: priority low, value above it.
  assign in_entry = s_axis_tdata_i[62:0];

  // The effective capacity is the smaller of the limit and the memory depth.
  assign heap_full = (CmpW'(occ_q) >= CmpW'(limit_q)) || (occ_q >= CntW'(HEAP_DEPTH));

  assign occ_inc = occ_q + CntW'(1);
  assign occ_dec = occ_q - CntW'(1);

  assign occ_wide = CmpW'(occ_q);
  assign inc_wide = CmpW'(occ_inc);
  assign dec_wide = CmpW'(occ_dec);

  // A finished result moves into the output register once that is free.
  assign out_load = (state_q == ST_FIN) && (!m_valid_q || m_axis_tready_i);

  // Tree navigation; the last entry index bounds the sift-down walk.
  assign parent_idx = (pos_q - AddrW'(1)) >> 1;
  assign left_idx   = {pos_q, 1'b1};
  assign right_idx  = left_idx + (AddrW + 1)'(1);
  assign left_ok    = left_idx < {1'b0, last_idx_q};
  assign right_ok   = right_idx < {1'b0, last_idx_q};

  // Memory access per state. Every write lands before any read of the same
  // slot, so no forwarding is needed.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = pos_q;
    ram_wdata = new_q;
    ram_re    = 1'b0;
    ram_raddr = '0;
    case (state_q)
      ST_INS_RD: begin
        if (pos_q == '0) begin
          ram_we = 1'b1;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = parent_idx;
        end
      end
      ST_INS_CMP: begin
        ram_we = 1'b1;
        if (ram_rdata.prio > new_q.prio) begin
          ram_wdata = ram_rdata;
        end
      end
      ST_RM_ROOT: begin
        ram_re    = 1'b1;
        ram_raddr = '0;
      end
      ST_RM_LAST: begin
        ram_re    = 1'b1;
        ram_raddr = last_idx_q;
      end
      ST_SD_CHK: begin
        if (left_ok) begin
          ram_re    = 1'b1;
          ram_raddr = left_idx[AddrW-1:0];
        end else begin
          ram_we = 1'b1;
        end
      end
      ST_SD_LEFT: begin
        if (right_ok) begin
          ram_re    = 1'b1;
          ram_raddr = right_idx[AddrW-1:0];
        end
      end
      ST_SD_DEC: begin
        ram_we = 1'b1;
        if (new_q.prio > child_q.prio) begin
          ram_wdata = child_q;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      limit_q      <= bmhpq_pkg::LimitReset;
      occ_q        <= '0;
      m_valid_q    <= 1'b0;
      pos_q        <= '0;
      last_idx_q   <= '0;
      child_idx_q  <= '0;
      new_q        <= '0;
      child_q      <= '0;
      res_status_q <= bmhpq_pkg::STATUS_DONE;
      res_entry_q  <= '0;
      out_status_q <= bmhpq_pkg::STATUS_DONE;
      out_entry_q  <= '0;
      res_cnt_q    <= '0;
      out_cnt_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      if (m_valid_q && m_axis_tready_i && !out_load) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_accept) begin
            res_entry_q <= '0;
            res_status_q <= bmhpq_pkg::STATUS_DONE;
            // During insert, new_q holds the moving entry; during removal,
            // it holds the former last entry being sifted down.
            new_q <= in_entry;
            if (!s_axis_tuser_i) begin
              if (heap_full) begin
                res_status_q <= bmhpq_pkg::STATUS_FULL;
                res_cnt_q    <= occ_wide[bmhpq_pkg::CountW-1:0];
                state_q      <= ST_FIN;
              end else begin
                pos_q     <= occ_q[AddrW-1:0];
                occ_q     <= occ_inc;
                res_cnt_q <= inc_wide[bmhpq_pkg::CountW-1:0];
                state_q   <= ST_INS_RD;
              end
            end else begin
              if (occ_q == '0) begin
                res_status_q <= bmhpq_pkg::STATUS_EMPTY;
                res_cnt_q    <= '0;
                state_q      <= ST_FIN;
              end else begin
                occ_q      <= occ_dec;
                last_idx_q <= occ_dec[AddrW-1:0];
                res_cnt_q  <= dec_wide[bmhpq_pkg::CountW-1:0];
                state_q    <= ST_RM_ROOT;
              end
            end
          end
        end
        ST_INS_RD: begin
          state_q <= (pos_q == '0) ? ST_FIN : ST_INS_CMP;
        end
        ST_INS_CMP: begin
          // The parent moves down only when strictly greater.
          if (ram_rdata.prio > new_q.prio) begin
            pos_q   <= parent_idx;
            state_q <= ST_INS_RD;
          end else begin
            state_q <= ST_FIN;
          end
        end
        ST_RM_ROOT: begin
          state_q <= ST_RM_LAST;
        end
        ST_RM_LAST: begin
          res_entry_q <= ram_rdata;
          state_q     <= ST_RM_CAP;
        end
        ST_RM_CAP: begin
          new_q   <= ram_rdata;
          pos_q   <= '0;
          state_q <= ST_SD_CHK;
        end
        ST_SD_CHK: begin
          state_q <= left_ok ? ST_SD_LEFT : ST_FIN;
        end
        ST_SD_LEFT: begin
          child_q     <= ram_rdata;
          child_idx_q <= left_idx[AddrW-1:0];
          state_q     <= right_ok ? ST_SD_RIGHT : ST_SD_DEC;
        end
        ST_SD_RIGHT: begin
          // The right child wins only when strictly smaller.
          if (ram_rdata.prio < child_q.prio) begin
            child_q     <= ram_rdata;
            child_idx_q <= right_idx[AddrW-1:0];
          end
          state_q <= ST_SD_DEC;
        end
        ST_SD_DEC: begin
          if (new_q.prio > child_q.prio) begin
            pos_q   <= child_idx_q;
            state_q <= ST_SD_CHK;
          end else begin
            state_q <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_load) begin
            m_valid_q    <= 1'b1;
            out_status_q <= res_status_q;
            out_entry_q  <= res_entry_q;
            out_cnt_q    <= res_cnt_q;
            state_q      <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tuser_o  = out_status_q;
  assign m_axis_tdata_o  = {6'b0, out_cnt_q, out_entry_q.val, out_entry_q.prio};

endmodule
